@@ hw/rtl/cbeo_pkg.sv @@
// ============================================================================
// cbeo_pkg: shared types and constants for the cursor blink escape observer
// Parser state codes, CSI/DCS flag structs, byte codes, register indexes.
// ============================================================================
package cbeo_pkg;

    // Parameter collection limits
    localparam int unsigned MAX_PARAMS      = 24;
    localparam int unsigned MAX_PARAM_VALUE = 65535;
    localparam int unsigned PARAM_W         = 16;
    localparam int unsigned PCOUNT_W        = 5;

    // Configuration register indexes
    localparam logic [1:0] REG_REQUESTS_ENABLED = 2'd0;
    localparam logic [1:0] REG_BLINK_POLICY     = 2'd1;
    localparam logic [1:0] REG_XOR_MODE         = 2'd2;

    // Blink policy codes
    localparam logic [1:0] POLICY_DEFAULT_OFF = 2'd0;
    localparam logic [1:0] POLICY_DEFAULT_ON  = 2'd1;
    localparam logic [1:0] POLICY_ALWAYS      = 2'd2;
    localparam logic [1:0] POLICY_NEVER       = 2'd3;

    // Byte codes
    localparam logic [7:0] B_BEL       = 8'h07;
    localparam logic [7:0] B_CAN       = 8'h18;
    localparam logic [7:0] B_SUB       = 8'h1a;
    localparam logic [7:0] B_ESC       = 8'h1b;
    localparam logic [7:0] B_SPACE     = 8'h20;
    localparam logic [7:0] B_BANG      = 8'h21;
    localparam logic [7:0] B_SEMI      = 8'h3b;
    localparam logic [7:0] B_QMARK     = 8'h3f;
    localparam logic [7:0] B_DCS_7     = 8'h50;
    localparam logic [7:0] B_SOS_7     = 8'h58;
    localparam logic [7:0] B_CSI_7     = 8'h5b;
    localparam logic [7:0] B_OSC_7     = 8'h5d;
    localparam logic [7:0] B_PM_7      = 8'h5e;
    localparam logic [7:0] B_APC_7     = 8'h5f;
    localparam logic [7:0] B_RIS       = 8'h63;
    localparam logic [7:0] F_SET       = 8'h68;
    localparam logic [7:0] F_RESET     = 8'h6c;
    localparam logic [7:0] F_SOFTRESET = 8'h70;
    localparam logic [7:0] F_STYLE     = 8'h71;
    localparam logic [7:0] F_RESTORE   = 8'h72;
    localparam logic [7:0] F_SAVE      = 8'h73;
    localparam logic [7:0] B_DCS_C1    = 8'h90;
    localparam logic [7:0] B_SOS_C1    = 8'h98;
    localparam logic [7:0] B_CSI_C1    = 8'h9b;
    localparam logic [7:0] B_ST_C1     = 8'h9c;
    localparam logic [7:0] B_OSC_C1    = 8'h9d;
    localparam logic [7:0] B_PM_C1     = 8'h9e;
    localparam logic [7:0] B_APC_C1    = 8'h9f;
    localparam logic [7:0] MODE_BLINK  = 8'd12;

    typedef enum logic [2:0] {
        ST_GROUND,
        ST_ESCAPE,
        ST_CSI,
        ST_DCSHDR,
        ST_STRING
    } parse_state_t;

    typedef enum logic [1:0] {
        SK_APC,
        SK_OSC,
        SK_DCS
    } string_kind_t;

    typedef struct packed {
        logic mode12;
        logic present;
        logic seen;
        logic invalid;
        logic priv;
    } csi_flags_t;

    typedef struct packed {
        csi_flags_t            flags;
        logic [7:0]            inter_byte;
        logic [7:0]            inter_count;
        logic [PARAM_W-1:0]    value;
        logic [PARAM_W-1:0]    first;
        logic [PCOUNT_W-1:0]   count;
    } csi_ctx_t;

    typedef struct packed {
        logic param;
        logic inter;
    } dcs_flags_t;

endpackage

@@ hw/rtl/cursor_blink_escape_observer.sv @@
// ============================================================================
// cursor_blink_escape_observer: escape parser tracking cursor blink requests
// Parses a terminal byte stream (ESC/CSI/DCS/strings, UTF-8 skip) and reports
// per byte whether the requested cursor blink changed or was reset.
// ============================================================================
// Byte accept to result valid passes the input register, then the result register.
// Throughput: one byte per cycle while no out_stall holds a full result; the
//   parser update is a single combinational pass between the two registers.
// Reset (rst_n low, async): parser in ground, blink request and saved state
//   clear, requests_enabled = 1, blink_policy = 0, xor_mode = 0.
// ============================================================================
module cursor_blink_escape_observer (
    input  logic       clk,
    input  logic       rst_n,
    // byte channel
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] byte_in,
    // result channel
    output logic       out_valid,
    input  logic       out_stall,
    output logic       blink_change,
    output logic       blink_reset,
    output logic       blink_requested,
    output logic       blink_effective,
    // configuration writes
    input  logic       cfg_we,
    input  logic [1:0] cfg_index,
    input  logic [1:0] cfg_data
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic       req_en_reg;
    logic [1:0] policy_reg;
    logic       xor_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_en_reg <= 1'b1;
            policy_reg <= cbeo_pkg::POLICY_DEFAULT_OFF;
            xor_reg    <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                cbeo_pkg::REG_REQUESTS_ENABLED: req_en_reg <= cfg_data[0];
                cbeo_pkg::REG_BLINK_POLICY:     policy_reg <= cfg_data;
                cbeo_pkg::REG_XOR_MODE:         xor_reg    <= cfg_data[0];
                default: ;  // unused index: write dropped
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Handshake: input register feeds the parser, result register holds
    // the answer. The parser fires whenever the result slot is free or
    // being drained, so a byte can enter every cycle.
    // ------------------------------------------------------------------
    logic       in_valid_reg;
    logic [7:0] byte_reg;
    logic       out_valid_reg;
    logic       proc_fire;

    assign proc_fire = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = in_valid_reg && out_valid_reg && out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            byte_reg <= byte_in;
        end
    end

    // ------------------------------------------------------------------
    // Parser state
    // ------------------------------------------------------------------
    cbeo_pkg::parse_state_t st_reg,     st_next;
    cbeo_pkg::string_kind_t kind_reg,   kind_next;
    logic [1:0]             utf_reg,    utf_next;
    cbeo_pkg::csi_ctx_t     csi_reg,    csi_next;
    cbeo_pkg::dcs_flags_t   dcs_reg,    dcs_next;
    logic                   req_reg,    req_next;
    logic                   sblink_reg, sblink_next;
    logic                   svalid_reg, svalid_next;

    logic                   chg_c;
    logic                   rst_c;
    logic                   done_c;
    logic                   raw_high_c;
    cbeo_pkg::csi_ctx_t     csi_end_c;
    logic [PROD_W-1:0]      prod_c;
    logic [cbeo_pkg::PARAM_W-1:0] style_c;

    localparam int unsigned PROD_W = cbeo_pkg::PARAM_W + 4;

    // Close the current parameter; mirrors the separator/final handling.
    function automatic cbeo_pkg::csi_ctx_t end_param(
        input cbeo_pkg::csi_ctx_t c,
        input logic               take_empty,
        input logic               separator
    );
        cbeo_pkg::csi_ctx_t r;
        r = c;
        if (c.flags.present || take_empty)
        begin
            if (c.count >= cbeo_pkg::PCOUNT_W'(cbeo_pkg::MAX_PARAMS))
            begin
                r.flags.invalid = 1'b1;
                r.flags.present = 1'b0;
                r.value         = '0;
            end
            else
            begin
                if (c.count == '0)
                begin
                    r.first = c.value;
                end
                r.count = c.count + 1'b1;
                if (c.value == cbeo_pkg::PARAM_W'(cbeo_pkg::MODE_BLINK))
                begin
                    r.flags.mode12 = 1'b1;
                end
                if (separator &&
                    r.count >= cbeo_pkg::PCOUNT_W'(cbeo_pkg::MAX_PARAMS))
                begin
                    r.flags.invalid = 1'b1;
                end
                r.flags.present = 1'b0;
                r.value         = '0;
            end
        end
        return r;
    endfunction

    // value*5 + digit, not used; the saturation test takes acc_c below
    assign prod_c = {2'b00, csi_reg.value, 2'b00} + {4'b0000, csi_reg.value}
                    + PROD_W'(byte_reg[3:0]);
    // note: {v,00}+v = 5v; doubled below
    logic [PROD_W-1:0] acc_c;
    assign acc_c = {1'b0, csi_reg.value, 3'b000} + {3'b000, csi_reg.value, 1'b0}
                   + PROD_W'(byte_reg[3:0]);

    assign csi_end_c = end_param(csi_reg, 1'b0, 1'b0);
    assign style_c   = (csi_end_c.count == '0) ? '0 : csi_end_c.first;
    assign raw_high_c = (st_reg == cbeo_pkg::ST_STRING) &&
                        (kind_reg == cbeo_pkg::SK_DCS || kind_reg == cbeo_pkg::SK_OSC);

    // Next-state logic: one byte, one pass.
    always_comb
    begin
        st_next     = st_reg;
        kind_next   = kind_reg;
        utf_next    = utf_reg;
        csi_next    = csi_reg;
        dcs_next    = dcs_reg;
        req_next    = req_reg;
        sblink_next = sblink_reg;
        svalid_next = svalid_reg;
        chg_c       = 1'b0;
        rst_c       = 1'b0;
        done_c      = 1'b0;

        // UTF-8 skipping in ground and string states
        if (st_reg == cbeo_pkg::ST_GROUND || st_reg == cbeo_pkg::ST_STRING)
        begin
            if (utf_reg != 2'd0)
            begin
                if (byte_reg >= 8'h80 && byte_reg <= 8'hbf)
                begin
                    utf_next = utf_reg - 2'd1;
                    done_c   = 1'b1;
                end
                else
                begin
                    utf_next = 2'd0;
                end
            end
            if (!done_c)
            begin
                if (byte_reg >= 8'hc2 && byte_reg <= 8'hdf)
                begin
                    utf_next = 2'd1;
                    done_c   = 1'b1;
                end
                else if (byte_reg >= 8'he0 && byte_reg <= 8'hef)
                begin
                    utf_next = 2'd2;
                    done_c   = 1'b1;
                end
                else if (byte_reg >= 8'hf0 && byte_reg <= 8'hf4)
                begin
                    utf_next = 2'd3;
                    done_c   = 1'b1;
                end
            end
        end

        // Controls valid in any state (C1 bytes are content in OSC/DCS strings)
        if (!done_c)
        begin
            if (byte_reg == cbeo_pkg::B_ESC)
            begin
                st_next = cbeo_pkg::ST_ESCAPE;
                done_c  = 1'b1;
            end
            else if (byte_reg == cbeo_pkg::B_CAN || byte_reg == cbeo_pkg::B_SUB)
            begin
                st_next = cbeo_pkg::ST_GROUND;
                done_c  = 1'b1;
            end
            else if (!(raw_high_c && byte_reg[7]))
            begin
                if (byte_reg == cbeo_pkg::B_CSI_C1)
                begin
                    st_next  = cbeo_pkg::ST_CSI;
                    csi_next = '0;
                    done_c   = 1'b1;
                end
                else if (byte_reg == cbeo_pkg::B_DCS_C1)
                begin
                    st_next  = cbeo_pkg::ST_DCSHDR;
                    dcs_next = '0;
                    done_c   = 1'b1;
                end
                else if (byte_reg == cbeo_pkg::B_OSC_C1)
                begin
                    st_next   = cbeo_pkg::ST_STRING;
                    kind_next = cbeo_pkg::SK_OSC;
                    done_c    = 1'b1;
                end
                else if (byte_reg == cbeo_pkg::B_SOS_C1 || byte_reg == cbeo_pkg::B_PM_C1 ||
                         byte_reg == cbeo_pkg::B_APC_C1)
                begin
                    st_next   = cbeo_pkg::ST_STRING;
                    kind_next = cbeo_pkg::SK_APC;
                    done_c    = 1'b1;
                end
                else if (byte_reg >= 8'h80 && byte_reg <= 8'h9f)
                begin
                    // ST and the remaining C1 controls
                    st_next = cbeo_pkg::ST_GROUND;
                    done_c  = 1'b1;
                end
            end
        end

        if (!done_c)
        begin
            case (st_reg)
                cbeo_pkg::ST_ESCAPE:
                begin
                    if (byte_reg == cbeo_pkg::B_CSI_7)
                    begin
                        st_next  = cbeo_pkg::ST_CSI;
                        csi_next = '0;
                    end
                    else if (byte_reg == cbeo_pkg::B_OSC_7)
                    begin
                        st_next   = cbeo_pkg::ST_STRING;
                        kind_next = cbeo_pkg::SK_OSC;
                    end
                    else if (byte_reg == cbeo_pkg::B_DCS_7)
                    begin
                        st_next  = cbeo_pkg::ST_DCSHDR;
                        dcs_next = '0;
                    end
                    else if (byte_reg == cbeo_pkg::B_SOS_7 || byte_reg == cbeo_pkg::B_PM_7 ||
                             byte_reg == cbeo_pkg::B_APC_7)
                    begin
                        st_next   = cbeo_pkg::ST_STRING;
                        kind_next = cbeo_pkg::SK_APC;
                    end
                    else
                    begin
                        if (byte_reg == cbeo_pkg::B_RIS)
                        begin
                            chg_c       = 1'b1;
                            rst_c       = 1'b1;
                            req_next    = 1'b0;
                            sblink_next = 1'b0;
                            svalid_next = 1'b0;
                        end
                        st_next = cbeo_pkg::ST_GROUND;
                    end
                end

                cbeo_pkg::ST_CSI:
                begin
                    if (byte_reg >= 8'h40 && byte_reg <= 8'h7e)
                    begin
                        // final byte
                        csi_next = csi_end_c;
                        st_next  = cbeo_pkg::ST_GROUND;
                        if (!csi_end_c.flags.invalid)
                        begin
                            if (byte_reg == cbeo_pkg::F_STYLE && !csi_end_c.flags.priv &&
                                csi_end_c.inter_count == 8'd1 &&
                                csi_end_c.inter_byte == cbeo_pkg::B_SPACE &&
                                csi_end_c.count <= cbeo_pkg::PCOUNT_W'(1))
                            begin
                                if (req_en_reg)
                                begin
                                    if (style_c == 16'd0 || style_c == 16'd1 ||
                                        style_c == 16'd3 || style_c == 16'd5)
                                    begin
                                        req_next = 1'b1;
                                        chg_c    = !req_reg;
                                    end
                                    else if (style_c == 16'd2 || style_c == 16'd4 ||
                                             style_c == 16'd6)
                                    begin
                                        req_next = 1'b0;
                                        chg_c    = req_reg;
                                    end
                                end
                            end
                            else if (req_en_reg && csi_end_c.flags.priv &&
                                     csi_end_c.inter_count == 8'd0 &&
                                     csi_end_c.flags.mode12)
                            begin
                                if (byte_reg == cbeo_pkg::F_SET)
                                begin
                                    req_next = 1'b1;
                                    chg_c    = !req_reg;
                                end
                                else if (byte_reg == cbeo_pkg::F_RESET)
                                begin
                                    req_next = 1'b0;
                                    chg_c    = req_reg;
                                end
                                else if (byte_reg == cbeo_pkg::F_SAVE)
                                begin
                                    sblink_next = req_reg;
                                    svalid_next = 1'b1;
                                end
                                else if (byte_reg == cbeo_pkg::F_RESTORE && svalid_reg)
                                begin
                                    req_next = sblink_reg;
                                    chg_c    = sblink_reg ^ req_reg;
                                end
                            end
                            else if (byte_reg == cbeo_pkg::F_SOFTRESET &&
                                     !csi_end_c.flags.priv &&
                                     csi_end_c.inter_count == 8'd1 &&
                                     csi_end_c.inter_byte == cbeo_pkg::B_BANG &&
                                     csi_end_c.count == '0)
                            begin
                                chg_c       = 1'b1;
                                rst_c       = 1'b1;
                                req_next    = 1'b0;
                                sblink_next = 1'b0;
                                svalid_next = 1'b0;
                            end
                        end
                    end
                    else if (byte_reg >= 8'h30 && byte_reg <= 8'h3f)
                    begin
                        // parameter bytes
                        if (csi_reg.inter_count != 8'd0)
                        begin
                            csi_next.flags.invalid = 1'b1;
                        end
                        else if (byte_reg == cbeo_pkg::B_QMARK && !csi_reg.flags.seen)
                        begin
                            csi_next.flags.priv = 1'b1;
                            csi_next.flags.seen = 1'b1;
                        end
                        else if (byte_reg == cbeo_pkg::B_SEMI)
                        begin
                            csi_next = end_param(csi_reg, 1'b1, 1'b1);
                            csi_next.flags.seen = 1'b1;
                        end
                        else if (byte_reg > 8'h39)
                        begin
                            csi_next.flags.seen    = 1'b1;
                            csi_next.flags.invalid = 1'b1;
                        end
                        else
                        begin
                            csi_next.flags.seen    = 1'b1;
                            csi_next.flags.present = 1'b1;
                            if (acc_c > PROD_W'(cbeo_pkg::MAX_PARAM_VALUE))
                            begin
                                csi_next.value =
                                    cbeo_pkg::PARAM_W'(cbeo_pkg::MAX_PARAM_VALUE);
                            end
                            else
                            begin
                                csi_next.value = acc_c[cbeo_pkg::PARAM_W-1:0];
                            end
                        end
                    end
                    else if (byte_reg >= 8'h20 && byte_reg <= 8'h2f)
                    begin
                        // intermediate bytes
                        csi_next = csi_end_c;
                        if (csi_reg.inter_count == 8'd0)
                        begin
                            csi_next.inter_byte = byte_reg;
                        end
                        if (csi_reg.inter_count != 8'hff)
                        begin
                            csi_next.inter_count = csi_reg.inter_count + 8'd1;
                        end
                    end
                end

                cbeo_pkg::ST_DCSHDR:
                begin
                    if (byte_reg >= 8'h40 && byte_reg <= 8'h7e)
                    begin
                        st_next   = cbeo_pkg::ST_STRING;
                        kind_next = cbeo_pkg::SK_DCS;
                    end
                    else if (byte_reg >= 8'h20 && byte_reg <= 8'h2f)
                    begin
                        dcs_next.inter = 1'b1;
                    end
                    else if (byte_reg >= 8'h30 && byte_reg <= 8'h3f)
                    begin
                        if (byte_reg == 8'h3a || dcs_reg.inter ||
                            (dcs_reg.param && byte_reg >= 8'h3c))
                        begin
                            st_next   = cbeo_pkg::ST_STRING;
                            kind_next = cbeo_pkg::SK_DCS;
                        end
                        else
                        begin
                            dcs_next.param = 1'b1;
                        end
                    end
                end

                cbeo_pkg::ST_STRING:
                begin
                    if (byte_reg == cbeo_pkg::B_BEL && kind_reg == cbeo_pkg::SK_OSC)
                    begin
                        st_next = cbeo_pkg::ST_GROUND;
                    end
                end

                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg     <= cbeo_pkg::ST_GROUND;
            kind_reg   <= cbeo_pkg::SK_APC;
            utf_reg    <= 2'd0;
            csi_reg    <= '0;
            dcs_reg    <= '0;
            req_reg    <= 1'b0;
            sblink_reg <= 1'b0;
            svalid_reg <= 1'b0;
        end
        else if (proc_fire)
        begin
            st_reg     <= st_next;
            kind_reg   <= kind_next;
            utf_reg    <= utf_next;
            csi_reg    <= csi_next;
            dcs_reg    <= dcs_next;
            req_reg    <= req_next;
            sblink_reg <= sblink_next;
            svalid_reg <= svalid_next;
        end
    end

    // ------------------------------------------------------------------
    // Output logic: effective blink from policy and combine mode
    // ------------------------------------------------------------------
    logic eff_c;
    logic dflt_c;

    always_comb
    begin
        dflt_c = (policy_reg == cbeo_pkg::POLICY_DEFAULT_ON);
        case (policy_reg)
            cbeo_pkg::POLICY_ALWAYS: eff_c = 1'b1;
            cbeo_pkg::POLICY_NEVER:  eff_c = 1'b0;
            default:                 eff_c = xor_reg ? (dflt_c ^ req_next)
                                                     : (dflt_c | req_next);
        endcase
    end

    // ------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------
    logic chg_reg, rst_flag_reg, req_out_reg, eff_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || !out_stall)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (proc_fire)
        begin
            chg_reg      <= chg_c;
            rst_flag_reg <= rst_c;
            req_out_reg  <= req_next;
            eff_reg      <= eff_c;
        end
    end

    assign out_valid       = out_valid_reg;
    assign blink_change    = chg_reg;
    assign blink_reset     = rst_flag_reg;
    assign blink_requested = req_out_reg;
    assign blink_effective = eff_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_result_from_fire: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(proc_fire))
        else $error("result appeared without a parser pass");

    a_reset_clears_req: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && blink_reset |-> blink_change && !blink_requested)
        else $error("reset result without change or with request set");

    a_utf_state: assert property (@(posedge clk) disable iff (!rst_n)
        utf_reg != 2'd0 |-> st_reg == cbeo_pkg::ST_GROUND || st_reg == cbeo_pkg::ST_STRING)
        else $error("UTF-8 skip pending outside ground/string");

    a_hold_no_fire: assert property (@(posedge clk) disable iff (!rst_n)
        !proc_fire |=> $stable(req_reg) && $stable(st_reg))
        else $error("parser state moved without a byte");

    a_param_count: assert property (@(posedge clk) disable iff (!rst_n)
        csi_reg.count <= cbeo_pkg::PCOUNT_W'(cbeo_pkg::MAX_PARAMS))
        else $error("parameter count beyond limit");

endmodule

@@ sim/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for cursor_blink_escape_observer
// Feeds terminal byte streams (blink requests, resets, strings, UTF-8, noise)
// under several register settings, predicts the blink flags of every byte
// and compares each result field against the prediction in arrival order.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import cbeo_pkg::*;

    // Bench constants
    localparam int unsigned RESULT_LATENCY  = 2;
    localparam int unsigned TAIL_CYCLES     = 4 * RESULT_LATENCY;
    localparam int unsigned IDLE_LIMIT      = 4000;
    localparam int unsigned PHASES          = 8;
    localparam int unsigned ITEMS_PER_PHASE = 62;
    localparam int unsigned PRINT_CAP       = 40;
    localparam int unsigned STYLE_MAX       = 6;

    // Register index with no register behind it
    localparam logic [1:0] REG_UNUSED = 2'd3;

    // Byte classes
    localparam logic [7:0] INTER_LO      = 8'h20;
    localparam logic [7:0] INTER_HI      = 8'h2f;
    localparam logic [7:0] PARAM_LO      = 8'h30;
    localparam logic [7:0] DIGIT_HI      = 8'h39;
    localparam logic [7:0] COLON         = 8'h3a;
    localparam logic [7:0] PRIV_LO       = 8'h3c;
    localparam logic [7:0] PARAM_HI      = 8'h3f;
    localparam logic [7:0] FINAL_LO      = 8'h40;
    localparam logic [7:0] BACKSLASH     = 8'h5c;
    localparam logic [7:0] FINAL_HI      = 8'h7e;
    localparam logic [7:0] DEL           = 8'h7f;
    localparam logic [7:0] C1_LO         = 8'h80;
    localparam logic [7:0] C1_HI         = 8'h9f;
    localparam logic [7:0] C0_PLAIN_HI   = 8'h17;
    localparam logic [7:0] HIGH_IGN_LO   = 8'ha0;
    localparam logic [7:0] UTF8_CONT_LO  = 8'h80;
    localparam logic [7:0] UTF8_CONT_HI  = 8'hbf;
    localparam logic [7:0] UTF8_LEAD2_LO = 8'hc2;
    localparam logic [7:0] UTF8_LEAD3_LO = 8'he0;
    localparam logic [7:0] UTF8_LEAD4_LO = 8'hf0;
    localparam logic [7:0] UTF8_LEAD_HI  = 8'hf4;

    typedef struct packed {
        logic change;
        logic reset_done;
        logic requested;
        logic effective;
    } blink_result_t;

    // ------------------------------------------------------------------------
    // Blink tracker: shadow copy of the parser and blink state, plus the
    // queue of flags each accepted byte should produce.
    // ------------------------------------------------------------------------
    class blink_tracker;
        bit            honor_requests;
        logic [1:0]    policy;
        bit            xor_combine;

        parse_state_t  pstate;
        string_kind_t  skind;
        int unsigned   utf8_left;
        csi_flags_t    csi;
        logic [7:0]    inter_byte;
        int unsigned   inter_count;
        int unsigned   param_val;
        int unsigned   param_first;
        int unsigned   param_cnt;
        dcs_flags_t    dcs;
        bit            blink_req;
        bit            saved_blink;
        bit            saved_valid;
        bit            saw_change;
        bit            saw_reset;

        blink_result_t blink_flags_q[$];
        int unsigned   errors;
        int unsigned   results_seen;

        function new();
            honor_requests = 1'b1;
            policy         = POLICY_DEFAULT_OFF;
            xor_combine    = 1'b0;
            pstate         = ST_GROUND;
            skind          = SK_APC;
            utf8_left      = 0;
            csi            = '0;
            inter_byte     = '0;
            inter_count    = 0;
            param_val      = 0;
            param_first    = 0;
            param_cnt      = 0;
            dcs            = '0;
            blink_req      = 1'b0;
            saved_blink    = 1'b0;
            saved_valid    = 1'b0;
            errors         = 0;
            results_seen   = 0;
        endfunction

        function int unsigned pending();
            return blink_flags_q.size();
        endfunction

        function void write_reg(logic [1:0] idx, logic [1:0] data);
            case (idx)
                REG_REQUESTS_ENABLED: honor_requests = data[0];
                REG_BLINK_POLICY:     policy = data;
                REG_XOR_MODE:         xor_combine = data[0];
                default: ;
            endcase
        endfunction

        function void start_csi();
            pstate      = ST_CSI;
            csi         = '0;
            inter_byte  = '0;
            inter_count = 0;
            param_val   = 0;
            param_first = 0;
            param_cnt   = 0;
        endfunction

        function void start_string(string_kind_t kind);
            pstate = ST_STRING;
            skind  = kind;
        endfunction

        function void start_dcs();
            pstate = ST_DCSHDR;
            dcs    = '0;
        endfunction

        function void full_reset();
            saw_change  = 1'b1;
            saw_reset   = 1'b1;
            blink_req   = 1'b0;
            saved_blink = 1'b0;
            saved_valid = 1'b0;
        endfunction

        function void set_request(bit v);
            if (blink_req != v) begin
                saw_change = 1'b1;
                blink_req  = v;
            end
        endfunction

        // Close the parameter being collected; a full list turns the
        // sequence invalid.
        function void close_param(bit take_empty, bit separator);
            if (!csi.present && !take_empty)
                return;
            if (param_cnt >= MAX_PARAMS) begin
                csi.invalid = 1'b1;
                csi.present = 1'b0;
                param_val   = 0;
                return;
            end
            if (param_cnt == 0)
                param_first = param_val;
            param_cnt++;
            if (param_val == MODE_BLINK)
                csi.mode12 = 1'b1;
            if (separator && param_cnt >= MAX_PARAMS)
                csi.invalid = 1'b1;
            csi.present = 1'b0;
            param_val   = 0;
        endfunction

        function void csi_param_byte(logic [7:0] b);
            int unsigned digit;
            if (b >= PARAM_LO) begin
                if (inter_count != 0) begin
                    csi.invalid = 1'b1;
                    return;
                end
                if (b == B_QMARK && !csi.seen) begin
                    csi.priv = 1'b1;
                    csi.seen = 1'b1;
                    return;
                end
                csi.seen = 1'b1;
                if (b == B_SEMI) begin
                    close_param(1'b1, 1'b1);
                    return;
                end
                if (b > DIGIT_HI) begin
                    csi.invalid = 1'b1;
                    return;
                end
                csi.present = 1'b1;
                digit = b - PARAM_LO;
                if (param_val > (MAX_PARAM_VALUE - digit) / 10)
                    param_val = MAX_PARAM_VALUE;
                else
                    param_val = param_val * 10 + digit;
            end else begin
                close_param(1'b0, 1'b0);
                if (inter_count == 0)
                    inter_byte = b;
                if (inter_count != 255)
                    inter_count++;
            end
        endfunction

        function void csi_final(logic [7:0] fin);
            int unsigned style;
            close_param(1'b0, 1'b0);
            if (csi.invalid)
                return;
            if (fin == F_STYLE && !csi.priv && inter_count == 1 && inter_byte == B_SPACE &&
                param_cnt <= 1) begin
                style = (param_cnt == 0) ? 0 : param_first;
                // odd styles and the default blink, even ones are steady
                if (honor_requests && style <= STYLE_MAX)
                    set_request(style == 0 || style % 2 == 1);
            end else if (honor_requests && csi.priv && inter_count == 0 && csi.mode12) begin
                if (fin == F_SET || fin == F_RESET)
                    set_request(fin == F_SET);
                else if (fin == F_SAVE) begin
                    saved_blink = blink_req;
                    saved_valid = 1'b1;
                end else if (fin == F_RESTORE && saved_valid)
                    set_request(saved_blink);
            end else if (fin == F_SOFTRESET && !csi.priv && inter_count == 1 &&
                         inter_byte == B_BANG && param_cnt == 0)
                full_reset();
        endfunction

        // ESC, cancel and C1 controls act in every state, except that OSC and
        // DCS strings keep high bytes as content.
        function bit take_global(logic [7:0] b);
            bit raw_high;
            raw_high = pstate == ST_STRING && (skind == SK_DCS || skind == SK_OSC);
            if (b == B_ESC) begin
                pstate = ST_ESCAPE;
                return 1'b1;
            end
            if (b == B_CAN || b == B_SUB) begin
                pstate = ST_GROUND;
                return 1'b1;
            end
            if (raw_high && b >= C1_LO)
                return 1'b0;
            case (b)
                B_CSI_C1: start_csi();
                B_DCS_C1: start_dcs();
                B_OSC_C1: start_string(SK_OSC);
                B_SOS_C1, B_PM_C1, B_APC_C1: start_string(SK_APC);
                default:
                begin
                    if (b < C1_LO || b > C1_HI)
                        return 1'b0;
                    pstate = ST_GROUND;
                end
            endcase
            return 1'b1;
        endfunction

        function void track_parse(logic [7:0] b);
            if (pstate == ST_GROUND || pstate == ST_STRING) begin
                if (utf8_left != 0) begin
                    if (b >= UTF8_CONT_LO && b <= UTF8_CONT_HI) begin
                        utf8_left--;
                        return;
                    end
                    utf8_left = 0;
                end
                if (b >= UTF8_LEAD2_LO && b <= UTF8_LEAD_HI) begin
                    utf8_left = (b >= UTF8_LEAD4_LO) ? 3 : (b >= UTF8_LEAD3_LO) ? 2 : 1;
                    return;
                end
            end
            if (take_global(b))
                return;
            case (pstate)
                ST_ESCAPE:
                begin
                    case (b)
                        B_CSI_7: start_csi();
                        B_OSC_7: start_string(SK_OSC);
                        B_DCS_7: start_dcs();
                        B_SOS_7, B_PM_7, B_APC_7: start_string(SK_APC);
                        default:
                        begin
                            if (b == B_RIS)
                                full_reset();
                            pstate = ST_GROUND;
                        end
                    endcase
                end
                ST_CSI:
                begin
                    if (b >= FINAL_LO && b <= FINAL_HI) begin
                        csi_final(b);
                        pstate = ST_GROUND;
                    end else if (b >= INTER_LO && b <= PARAM_HI)
                        csi_param_byte(b);
                end
                ST_DCSHDR:
                begin
                    if (b >= FINAL_LO && b <= FINAL_HI)
                        start_string(SK_DCS);
                    else if (b >= INTER_LO && b <= INTER_HI)
                        dcs.inter = 1'b1;
                    else if (b >= PARAM_LO && b <= PARAM_HI) begin
                        if (b == COLON || dcs.inter || (dcs.param && b >= PRIV_LO))
                            start_string(SK_DCS);
                        else
                            dcs.param = 1'b1;
                    end
                end
                ST_STRING:
                begin
                    if (b == B_BEL && skind == SK_OSC)
                        pstate = ST_GROUND;
                end
                default: ;
            endcase
        endfunction

        // Note one accepted byte and queue the flags it should produce.
        function void track_byte(logic [7:0] b);
            blink_result_t flags;
            bit            dflt;
            saw_change = 1'b0;
            saw_reset  = 1'b0;
            track_parse(b);
            flags.change     = saw_change;
            flags.reset_done = saw_reset;
            flags.requested  = blink_req;
            case (policy)
                POLICY_ALWAYS: flags.effective = 1'b1;
                POLICY_NEVER:  flags.effective = 1'b0;
                default:
                begin
                    dflt = (policy == POLICY_DEFAULT_ON);
                    flags.effective = xor_combine ? (dflt ^ blink_req) : (dflt | blink_req);
                end
            endcase
            blink_flags_q.push_back(flags);
        endfunction

        task report(string what);
            if (errors < PRINT_CAP)
                $display("[%0t] MISMATCH: %s", $time, what);
            errors++;
        endtask

        task check_field(string name, logic got, logic want);
            if (got !== want)
                report($sformatf("result %0d %s got %b want %b", results_seen, name, got, want));
        endtask

        // Compare one accepted result with the oldest queued flags.
        task compare_flags(blink_result_t got);
            blink_result_t want;
            results_seen++;
            if (blink_flags_q.size() == 0) begin
                report($sformatf("result %0d (%b) with nothing outstanding", results_seen, got));
                return;
            end
            want = blink_flags_q.pop_front();
            check_field("blink_change", got.change, want.change);
            check_field("blink_reset", got.reset_done, want.reset_done);
            check_field("blink_requested", got.requested, want.requested);
            check_field("blink_effective", got.effective, want.effective);
        endtask
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset and block ports. Every input starts at a known value.
    // ------------------------------------------------------------------------
    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    logic       in_stall;
    logic [7:0] byte_in   = '0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic       blink_change;
    logic       blink_reset;
    logic       blink_requested;
    logic       blink_effective;
    logic       cfg_we    = 1'b0;
    logic [1:0] cfg_index = '0;
    logic [1:0] cfg_data  = '0;

    blink_tracker tracker;
    int unsigned  burst_left   = 1;
    int unsigned  bytes_sent   = 0;
    int unsigned  idle_cycles  = 0;
    int unsigned  stall_ticks  = 0;
    int unsigned  stall_mode   = 0;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    cursor_blink_escape_observer u_top (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .byte_in         (byte_in),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .blink_change    (blink_change),
        .blink_reset     (blink_reset),
        .blink_requested (blink_requested),
        .blink_effective (blink_effective),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    // ------------------------------------------------------------------------
    // Result side: check on acceptance, then pick the next stall value.
    // The stall pattern switches between free flow, light and heavy random
    // stalls, and a fixed on/off rhythm.
    // ------------------------------------------------------------------------
    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall)
            tracker.compare_flags({blink_change, blink_reset, blink_requested,
                                   blink_effective});
        stall_ticks++;
        if (stall_ticks % 64 == 0)
            stall_mode = $urandom_range(0, 3);
        case (stall_mode)
            0: out_stall <= 1'b0;
            1: out_stall <= ($urandom_range(0, 3) == 0);
            2: out_stall <= ($urandom_range(0, 3) != 0);
            default: out_stall <= stall_ticks[2];
        endcase
    end

    // Watchdog: too long without any item moving on either channel.
    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles = 0;
        else begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("tb_top NOT OK");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Byte side. push_byte holds the item until it is taken, then notes it.
    // The sender runs in bursts; after a burst valid may drop for a gap.
    // ------------------------------------------------------------------------
    task automatic push_byte(input logic [7:0] b);
        int unsigned gap;
        byte_in  <= b;
        in_valid <= 1'b1;
        do @(posedge clk); while (in_stall);
        tracker.track_byte(b);
        bytes_sent++;
        if (burst_left > 0)
            burst_left--;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 6);
            if (gap != 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            // mostly short bursts, now and then a long unbroken stretch
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                      : $urandom_range(1, 12);
        end
    endtask

    // Stop sending and wait until every queued result has been checked.
    // Every byte yields a result, so nothing is left in flight after that.
    task automatic settle();
        in_valid <= 1'b0;
        while (tracker.pending() != 0)
            @(posedge clk);
    endtask

    // Write all registers (and the unused index) back to back while idle.
    task automatic write_settings(input bit en, input logic [1:0] pol, input bit xr);
        logic [1:0] idx_list [4];
        logic [1:0] data_list [4];
        int         k;
        idx_list[0]  = REG_REQUESTS_ENABLED;
        data_list[0] = $urandom_range(0, 3);
        data_list[0][0] = en;
        idx_list[1]  = REG_BLINK_POLICY;
        data_list[1] = pol;
        idx_list[2]  = REG_XOR_MODE;
        data_list[2] = $urandom_range(0, 3);
        data_list[2][0] = xr;
        idx_list[3]  = REG_UNUSED;
        data_list[3] = $urandom_range(0, 3);
        for (k = 0; k < 4; k++) begin
            cfg_we    <= 1'b1;
            cfg_index <= idx_list[k];
            cfg_data  <= data_list[k];
            @(posedge clk);
            tracker.write_reg(idx_list[k], data_list[k]);
        end
        cfg_we <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Stream pieces
    // ------------------------------------------------------------------------
    task automatic send_number(input int unsigned v);
        string s;
        int    k;
        s = $sformatf("%0d", v);
        for (k = 0; k < s.len(); k++)
            push_byte(s[k]);
    endtask

    task automatic send_csi_intro();
        if ($urandom_range(0, 1) != 0)
            push_byte(B_CSI_C1);
        else begin
            push_byte(B_ESC);
            push_byte(B_CSI_7);
        end
    endtask

    // Occasionally slip in a byte the CSI parser ignores.
    task automatic maybe_junk();
        int unsigned pick;
        if ($urandom_range(0, 9) != 0)
            return;
        pick = $urandom_range(0, 2);
        if (pick == 0)
            push_byte($urandom_range(0, C0_PLAIN_HI));
        else if (pick == 1)
            push_byte(DEL);
        else
            push_byte($urandom_range(HIGH_IGN_LO, 8'hff));
    endtask

    // Mostly the known styles, sometimes unknown ones and saturating values.
    function automatic int unsigned style_value();
        int unsigned pick;
        pick = $urandom_range(0, 9);
        if (pick < 8)
            return $urandom_range(0, STYLE_MAX + 2);
        else if (pick == 8)
            return $urandom_range(MAX_PARAM_VALUE - 3, MAX_PARAM_VALUE + 3);
        return $urandom_range(70000, 9999999);
    endfunction

    task automatic send_style();
        int unsigned n;
        send_csi_intro();
        if ($urandom_range(0, 19) == 0)
            push_byte(B_QMARK);
        n = $urandom_range(0, 9);
        if (n >= 5) begin
            send_number(style_value());
            maybe_junk();
        end
        if (n == 9) begin
            push_byte(B_SEMI);
            send_number(style_value());
        end
        push_byte(B_SPACE);
        maybe_junk();
        if ($urandom_range(0, 19) == 0)
            push_byte(B_SPACE);
        push_byte(($urandom_range(0, 19) == 0) ? $urandom_range(FINAL_LO, FINAL_HI) : F_STYLE);
    endtask

    // Private mode list, mostly carrying 12, ended by set/reset/save/restore or a random final.
    task automatic send_mode12();
        int unsigned n, at, k, pick;
        send_csi_intro();
        if ($urandom_range(0, 15) != 0)
            push_byte(B_QMARK);
        n  = $urandom_range(1, 3);
        at = $urandom_range(0, n - 1);
        for (k = 0; k < n; k++) begin
            if (k > 0)
                push_byte(B_SEMI);
            maybe_junk();
            if (k == at && $urandom_range(0, 15) != 0)
                send_number(MODE_BLINK);
            else if ($urandom_range(0, 4) != 0)
                send_number($urandom_range(0, 30));
        end
        if ($urandom_range(0, 9) == 0)
            push_byte(B_SEMI);
        pick = $urandom_range(0, 9);
        if (pick < 2)
            push_byte(F_SET);
        else if (pick < 4)
            push_byte(F_RESET);
        else if (pick < 6)
            push_byte(F_SAVE);
        else if (pick < 9)
            push_byte(F_RESTORE);
        else
            push_byte($urandom_range(FINAL_LO, FINAL_HI));
    endtask

    task automatic send_soft_reset();
        send_csi_intro();
        if ($urandom_range(0, 7) == 0)
            push_byte(B_QMARK);
        if ($urandom_range(0, 5) == 0)
            send_number($urandom_range(0, 3));
        push_byte(B_BANG);
        push_byte(F_SOFTRESET);
    endtask

    // Parameter lists right around the limit, with and without a trailing
    // separator, so that the too-many-parameters rule is hit on both sides.
    task automatic send_param_flood();
        int unsigned n, at, k;
        send_csi_intro();
        push_byte(B_QMARK);
        n  = $urandom_range(MAX_PARAMS - 2, MAX_PARAMS + 2);
        at = $urandom_range(0, n - 1);
        for (k = 0; k < n; k++) begin
            if (k > 0)
                push_byte(B_SEMI);
            send_number((k == at) ? MODE_BLINK : $urandom_range(0, 9));
        end
        if ($urandom_range(0, 3) == 0)
            push_byte(B_SEMI);
        push_byte(($urandom_range(0, 1) != 0) ? F_SET : F_RESET);
    endtask

    // A lead byte and its continuations, sometimes cut short.
    task automatic send_utf8();
        logic [7:0]  lead;
        int unsigned tail, k;
        lead = $urandom_range(UTF8_LEAD2_LO, UTF8_LEAD_HI);
        tail = (lead >= UTF8_LEAD4_LO) ? 3 : (lead >= UTF8_LEAD3_LO) ? 2 : 1;
        if ($urandom_range(0, 3) == 0)
            tail = $urandom_range(0, tail);
        push_byte(lead);
        for (k = 0; k < tail; k++)
            push_byte($urandom_range(UTF8_CONT_LO, UTF8_CONT_HI));
    endtask

    // OSC, DCS or SOS/PM/APC string with mixed content and a random end.
    task automatic send_string();
        int unsigned kind, n, k, pick;
        kind = $urandom_range(0, 2);
        if (kind == 0) begin
            if ($urandom_range(0, 1) != 0)
                push_byte(B_OSC_C1);
            else begin
                push_byte(B_ESC);
                push_byte(B_OSC_7);
            end
        end else if (kind == 1) begin
            if ($urandom_range(0, 1) != 0)
                push_byte(B_DCS_C1);
            else begin
                push_byte(B_ESC);
                push_byte(B_DCS_7);
            end
            repeat ($urandom_range(0, 4))
                push_byte($urandom_range(INTER_LO, PARAM_HI));
            push_byte($urandom_range(FINAL_LO, FINAL_HI));
        end else begin
            pick = $urandom_range(0, 5);
            if (pick < 3) begin
                push_byte(B_ESC);
                push_byte((pick == 0) ? B_SOS_7 : (pick == 1) ? B_PM_7 : B_APC_7);
            end else
                push_byte((pick == 3) ? B_SOS_C1 : (pick == 4) ? B_PM_C1 : B_APC_C1);
        end
        n = $urandom_range(0, 10);
        for (k = 0; k < n; k++) begin
            pick = $urandom_range(0, 9);
            if (pick < 6)
                push_byte($urandom_range(INTER_LO, FINAL_HI));
            else if (pick < 8)
                push_byte($urandom_range(C1_LO, 8'hff));
            else if (pick == 8)
                send_utf8();
            else
                push_byte($urandom_range(0, C0_PLAIN_HI));
        end
        pick = $urandom_range(0, 5);
        case (pick)
            0: push_byte(B_BEL);
            1: push_byte(B_ST_C1);
            2:
            begin
                push_byte(B_ESC);
                push_byte(BACKSLASH);
            end
            3: push_byte(B_CAN);
            4: push_byte(B_SUB);
            default: ;
        endcase
    endtask

    // CSI with arbitrary parameter/intermediate bytes and any final byte.
    task automatic send_broken_csi();
        send_csi_intro();
        repeat ($urandom_range(1, 6)) begin
            if ($urandom_range(0, 5) == 0)
                maybe_junk();
            push_byte($urandom_range(INTER_LO, PARAM_HI));
        end
        push_byte($urandom_range(FINAL_LO, FINAL_HI));
    endtask

    task automatic send_random_sequence();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 16)
            send_style();
        else if (pick < 36)
            send_mode12();
        else if (pick < 41)
            send_soft_reset();
        else if (pick < 45) begin
            push_byte(B_ESC);
            push_byte(B_RIS);
        end else if (pick < 48)
            send_param_flood();
        else if (pick < 56)
            send_utf8();
        else if (pick < 70)
            send_string();
        else if (pick < 80)
            send_broken_csi();
        else if (pick < 90)
            repeat ($urandom_range(1, 6))
                push_byte($urandom_range(0, 255));
        else
            repeat ($urandom_range(1, 8))
                push_byte($urandom_range(INTER_LO, FINAL_HI));
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        int unsigned phase;
        int unsigned phase_start;
        int          k;
        tracker = new();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part at reset settings: blink style with no parameter,
        // save / clear / restore through private mode 12, full reset,
        // soft reset, then the lowest and highest byte values.
        push_byte(B_ESC);
        push_byte(B_CSI_7);
        push_byte(B_SPACE);
        push_byte(F_STYLE);
        for (k = 0; k < 3; k++) begin
            push_byte(B_CSI_C1);
            push_byte(B_QMARK);
            send_number(MODE_BLINK);
            push_byte((k == 0) ? F_SAVE : (k == 1) ? F_RESET : F_RESTORE);
        end
        push_byte(B_ESC);
        push_byte(B_RIS);
        push_byte(B_CSI_C1);
        push_byte(B_BANG);
        push_byte(F_SOFTRESET);
        push_byte(8'h00);
        push_byte(8'hff);

        // Random part: each phase runs under its own register setting.
        // The schedule covers every policy, both xor settings and both
        // request settings, including the all-zero and all-one corners.
        for (phase = 0; phase < PHASES; phase++) begin
            settle();
            write_settings(phase[0] ^ phase[2], phase[1:0], phase[1] ^ phase[2]);
            phase_start = bytes_sent;
            while (bytes_sent - phase_start < ITEMS_PER_PHASE)
                send_random_sequence();
        end

        settle();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (tracker.pending() != 0)
            tracker.report($sformatf("%0d results never arrived", tracker.pending()));
        if (tracker.errors == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule

@@ files.f @@
hw/rtl/cbeo_pkg.sv
hw/rtl/cursor_blink_escape_observer.sv
sim/tb_top.sv
